// ===== hw/rtl/wfcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcf_pkg: shared types and constants of the 802.11 frame capture filter
// Capture mode codes, header offsets and the per-frame summary word.
// ----------------------------------------------------------------------------
package wfcf_pkg;

  // Capture mode codes; unlisted codes behave as raw
  localparam logic [2:0] MODE_RAW    = 3'd0;
  localparam logic [2:0] MODE_BEACON = 3'd1;
  localparam logic [2:0] MODE_PROBE  = 3'd2;
  localparam logic [2:0] MODE_DEAUTH = 3'd3;
  localparam logic [2:0] MODE_EAPOL  = 3'd4;
  localparam logic [2:0] MODE_WPS    = 3'd5;

  localparam logic [5:0] POS_MAX = 6'd63;

  // MAC header lengths
  localparam logic [5:0] HDR_3ADDR = 6'd24;
  localparam logic [5:0] HDR_4ADDR = 6'd30;
  localparam logic [5:0] HDR_QOS   = 6'd2;

  // Offsets from the start of the LLC header
  localparam logic [5:0] REL_SNAP_LAST  = 6'd5;
  localparam logic [5:0] REL_ETYPE_HI   = 6'd6;
  localparam logic [5:0] REL_ETYPE_LO   = 6'd7;
  localparam logic [5:0] REL_EAPOL_TYPE = 6'd9;
  localparam logic [5:0] REL_EAP_TYPE   = 6'd16;
  localparam logic [5:0] REL_VENDOR_0   = 6'd17;
  localparam logic [5:0] REL_VENDOR_1   = 6'd18;
  localparam logic [5:0] REL_VENDOR_2   = 6'd19;
  localparam logic [5:0] REL_WPS_LAST   = 6'd23;

  // Byte values
  localparam logic [7:0] ETYPE_HI    = 8'h88;
  localparam logic [7:0] ETYPE_LO    = 8'h8E;
  localparam logic [7:0] EAPOL_PKT   = 8'h00;
  localparam logic [7:0] EAP_EXPANDED = 8'hFE;
  localparam logic [7:0] VENDOR_0    = 8'h00;
  localparam logic [7:0] VENDOR_1    = 8'h37;
  localparam logic [7:0] VENDOR_2    = 8'h2A;

  // Frame types and management subtypes
  localparam logic [1:0] FTYPE_MGMT = 2'd0;
  localparam logic [1:0] FTYPE_DATA = 2'd2;
  localparam logic [3:0] SUB_BEACON = 4'd8;
  localparam logic [3:0] SUB_PROBE  = 4'd4;
  localparam logic [3:0] SUB_DEAUTH = 4'd12;

  // LLC/SNAP header AA AA 03 00 00 00
  function automatic logic [7:0] snap_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hAA;
      3'd1:    b = 8'hAA;
      3'd2:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Everything the decision needs about one finished frame
  typedef struct packed {
    logic       fc_ok;
    logic [1:0] ftype;
    logic [3:0] subtype;
    logic       protect;
    logic       llc_long;
    logic       wps_long;
    logic       snap_ok;
    logic       etype_ok;
    logic       eapol_ok;
    logic       eap_ok;
    logic       vendor_ok;
  } frame_summary_t;

endpackage

// ===== hw/rtl/wifi_frame_capture_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_frame_capture_filter: 802.11 frame capture filter
// Classifies a byte stream of 802.11 frames and gives one capture word per
// frame according to the configured capture mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one frame byte per word, frame control
//   first, last_byte high on the final byte. Bytes are taken one per cycle
//   while in_ready is high. Output channel (out_valid/out_ready): one capture
//   word per frame; the final byte's summary passes the queue and raises
//   out_valid when the result register is empty or being read.
//   Config channel (cfg_valid/cfg_ready): write filter_mode while idle;
//   always ready. Codes 0 raw, 1 beacon, 2 probe, 3 deauth, 4 eapol, 5 wps;
//   6 and 7 behave as raw.
//   Throughput: one byte per cycle while in_ready is high; frames of one byte
//   can follow each other back to back.
//   A two-word queue sits between intake and decision; when the receiver
//   stalls, the result register holds and the queue fills, and in_ready drops
//   only once two further frame results are waiting.
//   Reset (rst, synchronous): mode to raw, queue and result emptied, frame
//   tracking back to the start of a frame.
// ----------------------------------------------------------------------------
module wifi_frame_capture_filter import wfcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       capture,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] filter_mode
);

  frame_summary_t push_data;
  frame_summary_t pop_data;
  logic           push;
  logic           pop;
  logic           full;
  logic           not_empty;

  // Register writes are taken at once
  assign cfg_ready = 1'b1;

  // Intake: advance the position and match header fields per byte
  wfcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .q_full     (full),
    .q_push     (push),
    .q_data     (push_data)
  );

  // Hold finished frame summaries until the decision stage is free
  wfcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  // Decide and present the capture word
  wfcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_mode    (filter_mode),
    .q_not_empty (not_empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .capture     (capture)
  );

endmodule

// ===== hw/rtl/wfcf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcf_front: byte intake and header classification
// Tracks the byte position, frame control and field matches; pushes one
// summary word per frame on its final byte.
// ----------------------------------------------------------------------------
module wfcf_front import wfcf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     frame_byte,
  input  logic           last_byte,
  input  logic           q_full,
  output logic           q_push,
  output frame_summary_t q_data
);

  logic [5:0]  pos;
  logic [15:0] fc;
  logic        snap_ok;
  logic        etype_ok;
  logic        eapol_ok;
  logic        eap_ok;
  logic        vendor_ok;

  logic [15:0] fc_next;
  logic        snap_ok_next;
  logic        etype_ok_next;
  logic        eapol_ok_next;
  logic        eap_ok_next;
  logic        vendor_ok_next;
  logic [5:0]  hdr;
  logic [5:0]  rel;
  logic        in_llc;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hdr = (fc[8] && fc[9]) ? HDR_4ADDR : HDR_3ADDR;
    if (fc[7]) begin
      hdr = hdr + HDR_QOS;
    end
  end

  // Offset into the LLC header; header is at least 24 so pos 0/1 never match
  assign in_llc = (pos >= hdr);
  assign rel    = pos - hdr;

  always_comb begin
    fc_next        = fc;
    snap_ok_next   = snap_ok;
    etype_ok_next  = etype_ok;
    eapol_ok_next  = eapol_ok;
    eap_ok_next    = eap_ok;
    vendor_ok_next = vendor_ok;
    if (pos == 6'd0) begin
      fc_next[7:0] = frame_byte;
    end else if (pos == 6'd1) begin
      fc_next[15:8] = frame_byte;
    end else if (in_llc) begin
      if (rel <= REL_SNAP_LAST) begin
        if (frame_byte != snap_byte(rel[2:0])) begin
          snap_ok_next = 1'b0;
        end
      end else if (rel == REL_ETYPE_HI) begin
        etype_ok_next = (frame_byte == ETYPE_HI);
      end else if (rel == REL_ETYPE_LO) begin
        etype_ok_next = etype_ok && (frame_byte == ETYPE_LO);
      end else if (rel == REL_EAPOL_TYPE) begin
        eapol_ok_next = (frame_byte == EAPOL_PKT);
      end else if (rel == REL_EAP_TYPE) begin
        eap_ok_next = (frame_byte == EAP_EXPANDED);
      end else if (rel == REL_VENDOR_0) begin
        vendor_ok_next = (frame_byte == VENDOR_0);
      end else if (rel == REL_VENDOR_1) begin
        vendor_ok_next = vendor_ok && (frame_byte == VENDOR_1);
      end else if (rel == REL_VENDOR_2) begin
        vendor_ok_next = vendor_ok && (frame_byte == VENDOR_2);
      end
    end
  end

  assign q_push = accept && last_byte;

  always_comb begin
    q_data.fc_ok     = (pos != 6'd0);
    q_data.ftype     = fc_next[3:2];
    q_data.subtype   = fc_next[7:4];
    q_data.protect   = fc_next[14];
    q_data.llc_long  = in_llc && (rel >= REL_ETYPE_LO);
    q_data.wps_long  = in_llc && (rel >= REL_WPS_LAST);
    q_data.snap_ok   = snap_ok_next;
    q_data.etype_ok  = etype_ok_next;
    q_data.eapol_ok  = eapol_ok_next;
    q_data.eap_ok    = eap_ok_next;
    q_data.vendor_ok = vendor_ok_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      pos       <= '0;
      fc        <= '0;
      snap_ok   <= 1'b1;
      etype_ok  <= 1'b0;
      eapol_ok  <= 1'b0;
      eap_ok    <= 1'b0;
      vendor_ok <= 1'b0;
    end else if (accept) begin
      if (pos != POS_MAX) begin
        pos <= pos + 6'd1;
      end
      fc        <= fc_next;
      snap_ok   <= snap_ok_next;
      etype_ok  <= etype_ok_next;
      eapol_ok  <= eapol_ok_next;
      eap_ok    <= eap_ok_next;
      vendor_ok <= vendor_ok_next;
    end
  end

endmodule

// ===== hw/rtl/wfcf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcf_queue: two-entry summary queue
// Decouples the byte intake from the decision stage.
// ----------------------------------------------------------------------------
module wfcf_queue import wfcf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  frame_summary_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output frame_summary_t pop_data
);

  frame_summary_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/wfcf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcf_back: capture decision and result register
// Holds the capture mode, applies it to each frame summary and presents
// the decision word.
// ----------------------------------------------------------------------------
module wfcf_back import wfcf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_mode,
  input  logic           q_not_empty,
  input  frame_summary_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           capture
);

  logic [2:0] mode;
  logic       decision;
  logic       mgmt;
  logic       eapol;

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  assign mgmt  = q_data.fc_ok && (q_data.ftype == FTYPE_MGMT);
  assign eapol = q_data.fc_ok && (q_data.ftype == FTYPE_DATA) && q_data.llc_long &&
                 q_data.snap_ok && q_data.etype_ok;

  always_comb begin
    case (mode)
      MODE_BEACON: decision = mgmt && (q_data.subtype == SUB_BEACON);
      MODE_PROBE:  decision = mgmt && (q_data.subtype == SUB_PROBE);
      MODE_DEAUTH: decision = mgmt && (q_data.subtype == SUB_DEAUTH);
      MODE_EAPOL:  decision = (q_data.fc_ok && q_data.protect) || eapol;
      MODE_WPS:    decision = eapol && q_data.wps_long && q_data.eapol_ok &&
                              q_data.eap_ok && q_data.vendor_ok;
      default:     decision = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RAW;
    end else if (cfg_write) begin
      mode <= cfg_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      capture <= decision;
    end
  end

endmodule

// ===== hw/rtl/wfcf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcf_checker: port-level checks of the frame capture filter
// Watches the top-level ports only; bound to the top level.
// ----------------------------------------------------------------------------
module wfcf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic last_byte,
  input logic out_valid,
  input logic out_ready,
  input logic capture
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(capture))
    else $error("result word changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Intake only stops when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("intake stalled with empty output");

  // A result rising from empty comes from a final byte that the intake took and the queue passed on
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
    else $error("result appeared unexpectedly");

endmodule

bind wifi_frame_capture_filter wfcf_checker u_wfcf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .capture   (capture)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 802.11 frame capture filter
// Streams frames one byte per word into the filter and predicts the capture
// word of every finished frame from a behavioural model of the classifier.
// Directed frames cover the short-frame, header and mode-switch corners.
// Random phases then sweep every capture mode with well-formed EAPOL/WPS and
// management frames, broken copies of the EAPOL/WPS ones and plain noise,
// while both channels idle at random. One long receiver hold-off makes the
// filter stall its intake.
// ----------------------------------------------------------------------------
module tb;
  import wfcf_pkg::*;

  localparam int unsigned FRAME_MAX    = 80;     // longest frame built, past saturation
  localparam int unsigned DRAIN_CYCLES = 6;      // result latency plus margin
  localparam int unsigned HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int unsigned PHASE_BYTES  = 150;    // bytes per random mode phase
  localparam int unsigned PHASE_COUNT  = 10;

  // Code 7 is unassigned and must behave as raw
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  // LLC/SNAP header AA AA 03 00 00 00, first byte in the top octet
  localparam logic [47:0] LLC_SNAP = 48'hAAAA_0300_0000;

  typedef enum logic [2:0] {
    FK_EAPOL, FK_MGMT, FK_PROTECTED, FK_SHORT, FK_NOISE
  } frame_kind_e;

  typedef enum logic [1:0] {
    RDY_ALWAYS, RDY_ALTERNATE, RDY_RANDOM, RDY_BLOCKS
  } ready_style_e;

  // Per-frame tracking state of the predictor
  typedef struct {
    logic [5:0]  pos;
    logic [15:0] fc;
    logic        snap_ok;
    logic        etype_ok;
    logic        eapol_ok;
    logic        eap_ok;
    logic        vendor_ok;
  } frame_track_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic       capture;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] filter_mode;

  wifi_frame_capture_filter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .capture      (capture),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .filter_mode  (filter_mode)
  );

  // Predictor state: mode as last written, tracking of the frame in flight
  logic [2:0]   model_mode;
  frame_track_t trk;
  logic         capture_q[$];   // expected capture words, oldest first

  // Frame under construction
  logic [7:0]   frame_buf[FRAME_MAX];
  int unsigned  frame_len;

  int unsigned  burst_left;
  int unsigned  hold_request;
  int unsigned  err_count;
  int unsigned  bytes_sent;
  int unsigned  frames_sent;
  int unsigned  words_checked;
  int unsigned  captures_seen;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Far beyond the slowest legal run: every byte waiting out the longest
  // sender gap and every word the longest receiver stall, plus the hold-off
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $display("  run stopped by watchdog, %0d capture words still expected",
             capture_q.size());
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // MAC header length: 24, or 30 with both DS bits, plus 2 for QoS subtypes
  function automatic int unsigned mac_header_len(input logic [15:0] fc);
    int unsigned hdr;
    hdr = (fc[8] && fc[9]) ? 30 : 24;
    if (fc[7]) hdr += 2;
    return hdr;
  endfunction

  function automatic void clear_track();
    trk.pos       = '0;
    trk.fc        = '0;
    trk.snap_ok   = 1'b1;
    trk.etype_ok  = 1'b0;
    trk.eapol_ok  = 1'b0;
    trk.eap_ok    = 1'b0;
    trk.vendor_ok = 1'b0;
  endfunction

  // Fold one byte into the tracking state at the current position
  function automatic void track_byte(input logic [7:0] b);
    int unsigned p;
    int unsigned hdr;
    int unsigned off;
    p = trk.pos;
    if (p == 0) begin
      trk.fc[7:0] = b;
    end else if (p == 1) begin
      trk.fc[15:8] = b;
    end else begin
      hdr = mac_header_len(trk.fc);
      off = hdr + 8;
      if (p >= hdr && p < hdr + 6) begin
        if (b != LLC_SNAP[47 - 8 * (p - hdr) -: 8]) trk.snap_ok = 1'b0;
      end else if (p == hdr + 6) begin
        trk.etype_ok = (b == ETYPE_HI);
      end else if (p == hdr + 7) begin
        trk.etype_ok = trk.etype_ok && (b == ETYPE_LO);
      end else if (p == off + 1) begin
        trk.eapol_ok = (b == EAPOL_PKT);
      end else if (p == off + 8) begin
        trk.eap_ok = (b == EAP_EXPANDED);
      end else if (p == off + 9) begin
        trk.vendor_ok = (b == VENDOR_0);
      end else if (p == off + 10) begin
        trk.vendor_ok = trk.vendor_ok && (b == VENDOR_1);
      end else if (p == off + 11) begin
        trk.vendor_ok = trk.vendor_ok && (b == VENDOR_2);
      end
    end
  endfunction

  // Capture decision for a finished frame of len bytes
  function automatic logic capture_decision(input int unsigned len);
    logic [1:0]  ftype;
    logic [3:0]  sub;
    logic        fc_ok;
    logic        mgmt;
    logic        eapol;
    logic        verdict;
    int unsigned hdr;
    ftype = trk.fc[3:2];
    sub   = trk.fc[7:4];
    hdr   = mac_header_len(trk.fc);
    fc_ok = (len >= 2);
    mgmt  = fc_ok && (ftype == FTYPE_MGMT);
    eapol = fc_ok && (ftype == FTYPE_DATA) && (len >= hdr + 8) &&
            trk.snap_ok && trk.etype_ok;
    case (model_mode)
      MODE_BEACON: verdict = mgmt && (sub == SUB_BEACON);
      MODE_PROBE:  verdict = mgmt && (sub == SUB_PROBE);
      MODE_DEAUTH: verdict = mgmt && (sub == SUB_DEAUTH);
      MODE_EAPOL:  verdict = (fc_ok && trk.fc[14]) || eapol;
      MODE_WPS:    verdict = eapol && (len >= hdr + 24) && trk.eapol_ok &&
                             trk.eap_ok && trk.vendor_ok;
      default:     verdict = 1'b1;
    endcase
    return verdict;
  endfunction

  // Watch the input channel: predict on every accepted word
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      track_byte(frame_byte);
      if (last_byte) begin
        capture_q.push_back(capture_decision(int'(trk.pos) + 1));
        clear_track();
      end else if (trk.pos != POS_MAX) begin
        trk.pos = trk.pos + 6'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic want, input logic got);
    err_count++;
    $display("[%0t] MISMATCH %s: expected %0b, got %0b", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (capture === 1'b1) captures_seen++;
      if (capture_q.size() == 0) begin
        report_mismatch("capture word with none expected", 1'bx, capture);
      end else begin
        if (capture !== capture_q[0]) begin
          report_mismatch("capture", capture_q[0], capture);
        end
        void'(capture_q.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a style picked at random for a random stretch; a hold-off
  // request overrides it and is counted down here
  // --------------------------------------------------------------------------
  initial begin
    ready_style_e style;
    int unsigned  style_left;
    int unsigned  hold_left;
    int unsigned  tick;
    style      = RDY_ALWAYS;
    style_left = 0;
    hold_left  = 0;
    tick       = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = ready_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(16, 64);
        end
        style_left--;
        case (style)
          RDY_ALWAYS:    out_ready <= 1'b1;
          RDY_ALTERNATE: out_ready <= tick[0];
          RDY_RANDOM:    out_ready <= ($urandom_range(0, 2) != 0);
          default:       out_ready <= (tick % 16 < 11);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // Offer one byte; idle between bursts, then hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    last_byte  <= lst;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
    if (lst) frames_sent++;
  endtask

  task automatic send_frame();
    for (int unsigned k = 0; k < frame_len; k++) begin
      send_byte(frame_buf[k], k == frame_len - 1);
    end
  endtask

  // Drop valid, let the filter drain, then write the capture mode
  task automatic write_mode(input logic [2:0] m);
    in_valid <= 1'b0;
    do @(posedge clk); while (capture_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid    <= 1'b1;
    filter_mode  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    model_mode = m;
  endtask

  // Fill frame_buf/frame_len with a frame of the given kind
  task automatic build_frame(input frame_kind_e kind);
    int unsigned hdr;
    int unsigned off;
    logic [7:0]  fc0;
    logic [7:0]  fc1;
    for (int unsigned k = 0; k < FRAME_MAX; k++) frame_buf[k] = 8'($urandom);
    case (kind)
      FK_EAPOL: begin
        fc0 = 8'($urandom);
        fc0[3:2] = FTYPE_DATA;
        fc1 = 8'($urandom);
        fc1[6] = ($urandom_range(0, 3) == 0);
        frame_buf[0] = fc0;
        frame_buf[1] = fc1;
        hdr = mac_header_len({fc1, fc0});
        off = hdr + 8;
        for (int unsigned k = 0; k < 6; k++) frame_buf[hdr + k] = LLC_SNAP[47 - 8 * k -: 8];
        frame_buf[hdr + 6]  = ETYPE_HI;
        frame_buf[hdr + 7]  = ETYPE_LO;
        frame_buf[off + 1]  = EAPOL_PKT;
        frame_buf[off + 8]  = EAP_EXPANDED;
        frame_buf[off + 9]  = VENDOR_0;
        frame_buf[off + 10] = VENDOR_1;
        frame_buf[off + 11] = VENDOR_2;
        case ($urandom_range(0, 7))
          0:       frame_len = hdr + $urandom_range(0, 7);      // cut inside LLC
          1:       frame_len = off + $urandom_range(0, 15);     // short of WPS length
          2:       frame_len = $urandom_range(60, FRAME_MAX);   // up to and past saturation
          default: frame_len = off + 16 + $urandom_range(0, 4); // at or past WPS length
        endcase
        // Break one byte now and then
        if ($urandom_range(0, 4) == 0) begin
          frame_buf[$urandom_range(0, frame_len - 1)] = 8'($urandom);
        end
      end
      FK_MGMT: begin
        fc0 = 8'($urandom);
        fc0[3:2] = FTYPE_MGMT;
        case ($urandom_range(0, 3))
          0:       fc0[7:4] = SUB_BEACON;
          1:       fc0[7:4] = SUB_PROBE;
          2:       fc0[7:4] = SUB_DEAUTH;
          default: fc0[7:4] = 4'($urandom);
        endcase
        frame_buf[0] = fc0;
        frame_len = $urandom_range(1, 32);
      end
      FK_PROTECTED: begin
        frame_buf[1][6] = 1'b1;
        frame_len = $urandom_range(2, 40);
      end
      FK_SHORT: frame_len = $urandom_range(1, 2);
      default:  frame_len = $urandom_range(1, FRAME_MAX);
    endcase
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      build_frame(FK_EAPOL);
    else if (pick < 70) build_frame(FK_MGMT);
    else if (pick < 80) build_frame(FK_PROTECTED);
    else if (pick < 90) build_frame(FK_SHORT);
    else                build_frame(FK_NOISE);
    send_frame();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // One-byte frames fail every mode but raw and the spare codes, which behave as raw
  task automatic test_single_byte_frames();
    for (int m = 0; m < 8; m++) begin
      write_mode(3'(m));
      send_byte((m % 2 != 0) ? 8'hFF : 8'h00, 1'b1);
    end
  endtask

  // Two-byte frames with frame control at its extremes and on each subtype
  task automatic test_frame_control_extremes();
    write_mode(MODE_EAPOL);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    write_mode(MODE_BEACON);
    send_byte({SUB_BEACON, FTYPE_MGMT, 2'b00}, 1'b0);
    send_byte(8'h00, 1'b1);
    write_mode(MODE_PROBE);
    send_byte({SUB_PROBE, FTYPE_MGMT, 2'b00}, 1'b0);
    send_byte(8'h00, 1'b1);
    write_mode(MODE_DEAUTH);
    send_byte({SUB_DEAUTH, FTYPE_MGMT, 2'b11}, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // The mode at the final byte decides, not the mode at the first
  task automatic test_mode_switch_mid_frame();
    write_mode(MODE_RAW);
    send_byte({SUB_BEACON, FTYPE_MGMT, 2'b00}, 1'b0);
    send_byte(8'h00, 1'b0);
    write_mode(MODE_BEACON);
    send_byte(8'h5A, 1'b1);
    send_byte({SUB_PROBE, FTYPE_DATA, 2'b00}, 1'b0);
    send_byte(8'h00, 1'b0);
    write_mode(MODE_SPARE_7);
    send_byte(8'hA5, 1'b1);
  endtask

  // Hold the receiver off while short frames keep coming, so the result
  // queue fills and the intake stalls
  task automatic test_receiver_hold_off();
    write_mode(MODE_EAPOL);
    hold_request = HOLD_CYCLES;
    repeat (30) begin
      build_frame(FK_SHORT);
      send_frame();
    end
  endtask

  // Sweep every mode with a phase of random frames each, WPS and EAPOL twice
  task automatic test_random_frames();
    int unsigned budget;
    logic [2:0]  m;
    for (int unsigned i = 0; i < PHASE_COUNT; i++) begin
      if (i < 8)       m = 3'(i);
      else if (i == 8) m = MODE_WPS;
      else             m = MODE_EAPOL;
      write_mode(m);
      budget = bytes_sent + PHASE_BYTES;
      while (bytes_sent < budget) send_random_frame();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid     <= 1'b0;
    frame_byte   <= 8'h00;
    last_byte    <= 1'b0;
    cfg_valid    <= 1'b0;
    filter_mode  <= MODE_RAW;
    rst          <= 1'b1;
    model_mode    = MODE_RAW;
    burst_left    = 0;
    hold_request  = 0;
    err_count     = 0;
    bytes_sent    = 0;
    frames_sent   = 0;
    words_checked = 0;
    captures_seen = 0;
    clear_track();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_single_byte_frames();
    test_frame_control_extremes();
    test_mode_switch_mid_frame();
    test_receiver_hold_off();
    test_random_frames();

    // Drain: nothing left to send, wait out every expected word and then
    // some, so a stray word still gets caught
    in_valid <= 1'b0;
    while (capture_q.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes in %0d frames over all eight capture modes,",
             bytes_sent, frames_sent);
    $display("%0d capture words checked (%0d captured), one long receiver hold-off.",
             words_checked, captures_seen);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wfcf_pkg.sv
hw/rtl/wfcf_front.sv
hw/rtl/wfcf_queue.sv
hw/rtl/wfcf_back.sv
hw/rtl/wifi_frame_capture_filter.sv
hw/rtl/wfcf_checker.sv
dv/tb.sv
